>>> hw/rtl/tte_pkg.sv
// Shared types, character codes and script string tables for the template tag expander.
// Used by tte_ctrl, tte_dp, the top level and the checker; depends on nothing.
package tte_pkg;

    // Scanner modes.
    typedef enum logic [2:0] {
        M_TEXT,
        M_TEXT_LT,
        M_OPENER,
        M_CODE,
        M_CODE_PCT
    } mode_t;

    // Result kinds.
    localparam logic [1:0] K_BYTE   = 2'd0;
    localparam logic [1:0] K_DONE   = 2'd1;
    localparam logic [1:0] K_UNTERM = 2'd2;
    localparam logic [1:0] K_OVF    = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Script strings, first character in the top byte.
    localparam logic [8*10-1:0] S_PRINT  = "print :: \"";
    localparam logic [8*11-1:0] S_EXPR   = "( print :: ";
    localparam logic [8*2-1:0]  S_CEXPR  = ")\n";
    localparam logic [8*2-1:0]  S_LCLOSE = "\"\n";

    typedef enum logic [1:0] {
        STR_PRINT,
        STR_EXPR,
        STR_CEXPR,
        STR_LCLOSE
    } str_t;

    // Sources of an emitted byte.
    typedef enum logic [1:0] {
        SRC_ROM,
        SRC_ESC,
        SRC_VAL
    } src_t;

    // Values that a literal or code byte can take.
    typedef enum logic [2:0] {
        V_BYTE,
        V_WS,
        V_LT,
        V_PCT,
        V_LF
    } val_t;

    // Work phases of one item, in emission order.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_OVF,
        PH_REPLAY,
        PH_LT,
        PH_LITB,
        PH_LCLOSE,
        PH_EXPR,
        PH_PCT,
        PH_CODE,
        PH_CLOSE,
        PH_FREPLAY,
        PH_FLT,
        PH_FLCLOSE,
        PH_END,
        PH_FLUSH
    } phase_t;

    localparam int NPH = 15;

    // Sub steps of one literal byte.
    typedef enum logic [1:0] {
        LS_FETCH,
        LS_PRE,
        LS_ESC,
        LS_VAL
    } lsub_t;

    // Work that one item needs, decoded at accept.
    typedef struct packed {
        logic ovf;
        logic replay;
        logic lt;
        logic litb;
        logic lclose;
        logic expr;
        logic pct;
        logic code;
        logic close_expr;
        logic close_nl;
        logic last;
        logic fin_text;
        logic fin_lt;
    } plan_t;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [1:0] kind;
        src_t       src;
        str_t       str_id;
        logic [3:0] str_idx;
        val_t       val;
        logic       set_lit_open;
        logic       clr_lit_open;
        logic       clr_ws;
        logic       flush;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        plan_t plan;
        logic  lit_open;
        logic  emit_ok;
        logic  flush_ok;
        logic  b_quote;
        logic  q_quote;
    } status_t;

    function automatic logic [7:0] str_char(str_t id, logic [3:0] i);
        logic [7:0] c;
        c = '0;
        case (id)
            STR_PRINT:  c = S_PRINT[8*(9-i) +: 8];
            STR_EXPR:   c = S_EXPR[8*(10-i) +: 8];
            STR_CEXPR:  c = S_CEXPR[8*(1-i) +: 8];
            default:    c = S_LCLOSE[8*(1-i) +: 8];
        endcase
        return c;
    endfunction

    function automatic logic [3:0] str_last(str_t id);
        logic [3:0] n;
        n = '0;
        case (id)
            STR_PRINT: n = 4'd9;
            STR_EXPR:  n = 4'd10;
            default:   n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/template_tag_expander.sv
// Template tag expander: takes one template byte per item and returns the
// script bytes that it produces. Literal text becomes print :: "..." lines
// with quotes escaped, <% code %> bodies pass through, <%= expr %> becomes
// ( print :: expr ). Indentation before a tag is held in a WS_DEPTH-entry
// RAM and dropped or replayed later; a kind 3 result flags the first time
// that buffer overflows. The final byte (s_is_last) closes the stream with a
// done result, or with an unterminated-block result giving the line and
// column of its opening '<', and then all scanner state returns to reset.
// m_run_end marks the last result of each item. An item passes through an
// accept step, the steps that emit its results, and a flush step. Steps that
// emit nothing still take time: each replayed whitespace byte needs a fetch
// step for the registered read of the buffer RAM, every replay (even of an
// empty buffer) ends with a check step, and a literal close with no literal
// open still passes through an idle step. Literal openers, expression
// prefixes and replayed indentation lengthen an item further. The next item
// is accepted only after the flush of the current one, and the flush waits
// for a free output register, so a stalled sink holds off the input.
// Depends on tte_pkg, tte_ctrl, tte_dp and tte_ram.
module template_tag_expander
    import tte_pkg::*;
#(
    parameter int WS_DEPTH = 16,
    parameter int POS_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_err_line,
    output logic [15:0] m_err_col,
    output logic        m_run_end
);
    localparam int CW = $clog2(WS_DEPTH + 1);

    // command and status between the sequencer and the datapath
    cmd_t          cmd;
    status_t       st;
    logic [CW-1:0] ws_count;
    logic [CW-1:0] rd_idx;

    tte_ctrl #(.WS_DEPTH(WS_DEPTH)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .st       (st),
        .ws_count (ws_count),
        .rd_idx   (rd_idx),
        .cmd      (cmd)
    );

    tte_dp #(.WS_DEPTH(WS_DEPTH), .POS_BITS(POS_BITS)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_in_byte  (s_in_byte),
        .s_is_last  (s_is_last),
        .cmd        (cmd),
        .rd_idx     (rd_idx),
        .st         (st),
        .ws_count   (ws_count),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_out_byte (m_out_byte),
        .m_err_line (m_err_line),
        .m_err_col  (m_err_col),
        .m_run_end  (m_run_end)
    );
endmodule

>>> hw/rtl/tte_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/tte_ctrl.sv
// Controller of the template tag expander: walks the phases of one item.
// Depends on tte_pkg.
module tte_ctrl
    import tte_pkg::*;
#(
    parameter int WS_DEPTH = 16,
    localparam int CW = $clog2(WS_DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  status_t               st,
    input  logic [CW-1:0]         ws_count,
    output logic [CW-1:0]         rd_idx,
    output cmd_t                  cmd
);
    phase_t        phase_reg, phase_next, nxt;
    lsub_t         lsub_reg, lsub_next;
    logic [3:0]    sidx_reg, sidx_next;
    logic [CW-1:0] ridx_reg, ridx_next;
    plan_t         plan_reg, plan_next, plan_use;
    logic [NPH-1:0] want;
    logic          advance, is_replay, quote;
    val_t          lit_val;

    assign rd_idx = ridx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            lsub_reg  <= LS_PRE;
            sidx_reg  <= '0;
            ridx_reg  <= '0;
            plan_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            lsub_reg  <= lsub_next;
            sidx_reg  <= sidx_next;
            ridx_reg  <= ridx_next;
            plan_reg  <= plan_next;
        end
    end

    // Pick the next phase that this item needs.
    always_comb begin
        plan_use = (phase_reg == PH_IDLE) ? st.plan : plan_reg;
        want = '0;
        want[PH_OVF]     = plan_use.ovf;
        want[PH_REPLAY]  = plan_use.replay;
        want[PH_LT]      = plan_use.lt;
        want[PH_LITB]    = plan_use.litb;
        want[PH_LCLOSE]  = plan_use.lclose;
        want[PH_EXPR]    = plan_use.expr;
        want[PH_PCT]     = plan_use.pct;
        want[PH_CODE]    = plan_use.code;
        want[PH_CLOSE]   = plan_use.close_expr | plan_use.close_nl;
        want[PH_FREPLAY] = plan_use.fin_text;
        want[PH_FLT]     = plan_use.fin_lt;
        want[PH_FLCLOSE] = plan_use.fin_text;
        want[PH_END]     = plan_use.last;
        want[PH_FLUSH]   = 1'b1;
        nxt = PH_FLUSH;
        for (int i = NPH - 1; i >= 0; i--) begin
            if (want[i] && (i > int'(phase_reg))) begin
                nxt = phase_t'(4'(i));
            end
        end
    end

    assign is_replay = (phase_reg == PH_REPLAY) || (phase_reg == PH_FREPLAY);

    always_comb begin
        case (phase_reg)
            PH_REPLAY, PH_FREPLAY: lit_val = V_WS;
            PH_LT, PH_FLT:         lit_val = V_LT;
            default:               lit_val = V_BYTE;
        endcase
        quote = (lit_val == V_WS) ? st.q_quote : ((lit_val == V_BYTE) ? st.b_quote : 1'b0);
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        advance    = 1'b0;
        phase_next = phase_reg;
        lsub_next  = lsub_reg;
        sidx_next  = sidx_reg;
        ridx_next  = ridx_reg;
        plan_next  = plan_reg;

        unique case (phase_reg)
            PH_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    plan_next  = st.plan;
                    advance    = 1'b1;
                end
            end
            PH_OVF: begin
                cmd.emit = 1'b1;
                cmd.kind = K_OVF;
                advance  = st.emit_ok;
            end
            PH_REPLAY, PH_FREPLAY, PH_LT, PH_LITB, PH_FLT: begin
                if (is_replay && lsub_reg == LS_FETCH) begin
                    if (ridx_reg == ws_count) begin
                        cmd.clr_ws = 1'b1;
                        advance    = 1'b1;
                    end else begin
                        lsub_next = LS_PRE;
                    end
                end else if (lsub_reg == LS_PRE && !st.lit_open) begin
                    // open a literal line first
                    cmd.emit    = 1'b1;
                    cmd.src     = SRC_ROM;
                    cmd.str_id  = STR_PRINT;
                    cmd.str_idx = sidx_reg;
                    if (st.emit_ok) begin
                        if (sidx_reg == str_last(STR_PRINT)) begin
                            cmd.set_lit_open = 1'b1;
                            sidx_next        = '0;
                            lsub_next        = LS_ESC;
                        end else begin
                            sidx_next = sidx_reg + 4'd1;
                        end
                    end
                end else if (lsub_reg != LS_VAL && quote) begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_ESC;
                    if (st.emit_ok) begin
                        lsub_next = LS_VAL;
                    end
                end else begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_VAL;
                    cmd.val  = lit_val;
                    if (st.emit_ok) begin
                        if (is_replay) begin
                            ridx_next = ridx_reg + 1'b1;
                            lsub_next = LS_FETCH;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                end
            end
            PH_LCLOSE, PH_FLCLOSE: begin
                if (!st.lit_open) begin
                    advance = 1'b1;
                end else begin
                    cmd.emit    = 1'b1;
                    cmd.src     = SRC_ROM;
                    cmd.str_id  = STR_LCLOSE;
                    cmd.str_idx = sidx_reg;
                    if (st.emit_ok) begin
                        if (sidx_reg == str_last(STR_LCLOSE)) begin
                            cmd.clr_lit_open = 1'b1;
                            advance          = 1'b1;
                        end else begin
                            sidx_next = sidx_reg + 4'd1;
                        end
                    end
                end
            end
            PH_EXPR, PH_CLOSE: begin
                if (phase_reg == PH_CLOSE && !plan_reg.close_expr) begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_VAL;
                    cmd.val  = V_LF;
                    advance  = st.emit_ok;
                end else begin
                    cmd.emit    = 1'b1;
                    cmd.src     = SRC_ROM;
                    cmd.str_id  = (phase_reg == PH_EXPR) ? STR_EXPR : STR_CEXPR;
                    cmd.str_idx = sidx_reg;
                    if (st.emit_ok) begin
                        if (sidx_reg == str_last(cmd.str_id)) begin
                            advance = 1'b1;
                        end else begin
                            sidx_next = sidx_reg + 4'd1;
                        end
                    end
                end
            end
            PH_PCT, PH_CODE: begin
                cmd.emit = 1'b1;
                cmd.src  = SRC_VAL;
                cmd.val  = (phase_reg == PH_PCT) ? V_PCT : V_BYTE;
                advance  = st.emit_ok;
            end
            PH_END: begin
                cmd.emit = 1'b1;
                cmd.kind = plan_reg.fin_text ? K_DONE : K_UNTERM;
                advance  = st.emit_ok;
            end
            PH_FLUSH: begin
                cmd.flush = 1'b1;
                if (st.flush_ok) begin
                    cmd.finish = plan_reg.last;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        if (advance) begin
            phase_next = nxt;
            lsub_next  = (nxt == PH_REPLAY || nxt == PH_FREPLAY) ? LS_FETCH : LS_PRE;
            sidx_next  = '0;
            ridx_next  = '0;
        end
    end
endmodule

>>> hw/rtl/tte_dp.sv
// Datapath of the template tag expander: scanner state, whitespace buffer,
// position counters, decode of the incoming byte and the result stage/output.
// Depends on tte_pkg and tte_ram.
module tte_dp
    import tte_pkg::*;
#(
    parameter int WS_DEPTH = 16,
    parameter int POS_BITS = 16,
    localparam int CW = $clog2(WS_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        s_in_byte,
    input  logic              s_is_last,
    input  cmd_t              cmd,
    input  logic [CW-1:0]     rd_idx,
    output status_t           st,
    output logic [CW-1:0]     ws_count,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [7:0]        m_out_byte,
    output logic [15:0]       m_err_line,
    output logic [15:0]       m_err_col,
    output logic              m_run_end
);
    localparam int AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam int MAX_RES = 32;
    localparam logic [POS_BITS-1:0] PMAX = {POS_BITS{1'b1}};

    mode_t               mode_reg, mode_next;
    logic                expr_reg, expr_next;
    logic                lit_reg;
    logic                blank_reg, blank_next;
    logic                after_reg, after_next;
    logic                skip_reg, skip_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic                cne_reg, cne_next;
    logic                cln_reg, cln_next;
    logic [POS_BITS-1:0] line_reg, line_next, col_reg, col_next;
    logic [POS_BITS-1:0] bline_reg, bline_next, bcol_reg, bcol_next;
    logic [7:0]          b_reg;
    logic [5:0]          res_cnt_reg;

    logic                stg_valid_reg;
    logic [1:0]          stg_kind_reg;
    logic [7:0]          stg_byte_reg;
    logic [15:0]         stg_line_reg, stg_col_reg;
    logic                m_valid_reg, m_run_end_reg;
    logic [1:0]          m_kind_reg;
    logic [7:0]          m_byte_reg;
    logic [15:0]         m_line_reg, m_col_reg;

    plan_t               plan;
    logic                hws, ws_push, do_code, ci_skip;
    logic [7:0]          b, ram_q, e_byte;
    logic [15:0]         bl16, bc16;
    logic                out_free, emit_fire, flush_fire;

    assign b = s_in_byte;
    assign hws = (b == CH_SP) || (b == CH_TAB) || (b == CH_CR);

    tte_ram #(.WIDTH(8), .DEPTH(WS_DEPTH)) u_ws_ram (
        .aclk  (aclk),
        .we    (cmd.accept && ws_push),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (b),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_q)
    );

    // Decode the incoming byte against the scanner state.
    always_comb begin
        plan       = '0;
        ws_push    = 1'b0;
        do_code    = 1'b0;
        mode_next  = mode_reg;
        expr_next  = expr_reg;
        blank_next = blank_reg;
        after_next = after_reg;
        skip_next  = skip_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        cne_next   = cne_reg;
        cln_next   = cln_reg;
        bline_next = bline_reg;
        bcol_next  = bcol_reg;
        ci_skip    = skip_reg;

        case (mode_reg)
            M_TEXT_LT: begin
                if (b == CH_PCT) begin
                    if (blank_reg) begin
                        cnt_next = '0;
                    end
                    plan.lclose = 1'b1;
                    mode_next   = M_OPENER;
                end else begin
                    plan.replay = 1'b1;
                    plan.lt     = 1'b1;
                    after_next  = 1'b0;
                    if (b == CH_LT) begin
                        blank_next = 1'b0;
                        bline_next = line_reg;
                        bcol_next  = col_reg;
                        mode_next  = M_TEXT_LT;
                    end else begin
                        plan.litb  = 1'b1;
                        blank_next = (b == CH_LF);
                        mode_next  = M_TEXT;
                    end
                end
            end
            M_OPENER: begin
                mode_next = M_CODE;
                skip_next = 1'b1;
                cne_next  = 1'b0;
                cln_next  = 1'b0;
                if (b == CH_EQ) begin
                    expr_next = 1'b1;
                    plan.expr = 1'b1;
                end else begin
                    expr_next = 1'b0;
                    do_code   = 1'b1;
                    ci_skip   = 1'b1;
                end
            end
            M_CODE: begin
                do_code = 1'b1;
            end
            M_CODE_PCT: begin
                if (b == CH_GT) begin
                    plan.close_expr = expr_reg;
                    plan.close_nl   = !expr_reg && cne_reg && !cln_reg;
                    expr_next  = 1'b0;
                    cne_next   = 1'b0;
                    cln_next   = 1'b0;
                    mode_next  = M_TEXT;
                    after_next = 1'b1;
                    blank_next = 1'b1;
                    cnt_next   = '0;
                end else begin
                    plan.pct  = 1'b1;
                    cne_next  = 1'b1;
                    cln_next  = 1'b0;
                    mode_next = M_CODE;
                    do_code   = 1'b1;
                end
            end
            default: begin
                mode_next = M_TEXT;
                if (hws) begin
                    if (blank_reg) begin
                        if (cnt_reg < CW'(WS_DEPTH)) begin
                            ws_push  = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end else begin
                            // buffer full: give up trimming this line
                            plan.ovf    = !ovf_reg;
                            ovf_next    = 1'b1;
                            plan.replay = 1'b1;
                            plan.litb   = 1'b1;
                            blank_next  = 1'b0;
                            after_next  = 1'b0;
                        end
                    end else begin
                        plan.litb = 1'b1;
                    end
                end else if (b == CH_LF && after_reg) begin
                    cnt_next   = '0;
                    after_next = 1'b0;
                    blank_next = 1'b1;
                end else begin
                    after_next = 1'b0;
                    if (b == CH_LT) begin
                        bline_next = line_reg;
                        bcol_next  = col_reg;
                        mode_next  = M_TEXT_LT;
                    end else begin
                        plan.replay = 1'b1;
                        plan.litb   = 1'b1;
                        blank_next  = (b == CH_LF);
                    end
                end
            end
        endcase

        if (do_code) begin
            if (ci_skip && hws) begin
                skip_next = 1'b1;
            end else if (ci_skip && b == CH_LF) begin
                skip_next = 1'b0;
            end else begin
                skip_next = 1'b0;
                if (b == CH_PCT) begin
                    mode_next = M_CODE_PCT;
                end else begin
                    plan.code = 1'b1;
                    cne_next  = 1'b1;
                    cln_next  = (b == CH_LF);
                end
            end
        end

        if (b == CH_LF) begin
            line_next = (line_reg == PMAX) ? line_reg : line_reg + 1'b1;
            col_next  = POS_BITS'(1);
        end else begin
            line_next = line_reg;
            col_next  = (col_reg == PMAX) ? col_reg : col_reg + 1'b1;
        end

        plan.last     = s_is_last;
        plan.fin_text = s_is_last && (mode_next == M_TEXT || mode_next == M_TEXT_LT);
        plan.fin_lt   = s_is_last && (mode_next == M_TEXT_LT);
    end

    // Scanner state; clear it all after the end of a stream.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.finish) begin
            mode_reg  <= M_TEXT;
            expr_reg  <= 1'b0;
            lit_reg   <= 1'b0;
            blank_reg <= 1'b1;
            after_reg <= 1'b0;
            skip_reg  <= 1'b0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            cne_reg   <= 1'b0;
            cln_reg   <= 1'b0;
            line_reg  <= POS_BITS'(1);
            col_reg   <= POS_BITS'(1);
            bline_reg <= '0;
            bcol_reg  <= '0;
        end else begin
            if (cmd.accept) begin
                mode_reg  <= mode_next;
                expr_reg  <= expr_next;
                blank_reg <= blank_next;
                after_reg <= after_next;
                skip_reg  <= skip_next;
                cnt_reg   <= cnt_next;
                ovf_reg   <= ovf_next;
                cne_reg   <= cne_next;
                cln_reg   <= cln_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
                bline_reg <= bline_next;
                bcol_reg  <= bcol_next;
            end
            if (cmd.set_lit_open) begin
                lit_reg <= 1'b1;
            end
            if (cmd.clr_lit_open) begin
                lit_reg <= 1'b0;
            end
            if (cmd.clr_ws) begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            b_reg <= b;
        end
    end

    generate
        if (POS_BITS > 16) begin : g_sat
            assign bl16 = (|bline_reg[POS_BITS-1:16]) ? 16'hFFFF : bline_reg[15:0];
            assign bc16 = (|bcol_reg[POS_BITS-1:16]) ? 16'hFFFF : bcol_reg[15:0];
        end else begin : g_nosat
            assign bl16 = 16'(bline_reg);
            assign bc16 = 16'(bcol_reg);
        end
    endgenerate

    always_comb begin
        case (cmd.src)
            SRC_ROM: e_byte = str_char(cmd.str_id, cmd.str_idx);
            SRC_ESC: e_byte = CH_BSLASH;
            default: begin
                case (cmd.val)
                    V_BYTE:  e_byte = b_reg;
                    V_WS:    e_byte = ram_q;
                    V_LT:    e_byte = CH_LT;
                    V_PCT:   e_byte = CH_PCT;
                    default: e_byte = CH_LF;
                endcase
            end
        endcase
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign emit_fire  = cmd.emit && (!stg_valid_reg || out_free);
    assign flush_fire = cmd.flush && (!stg_valid_reg || out_free);

    // One result is staged so that the last of an item can carry run_end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            res_cnt_reg   <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit_fire && res_cnt_reg < 6'(MAX_RES)) begin
                res_cnt_reg   <= res_cnt_reg + 6'd1;
                stg_valid_reg <= 1'b1;
                if (stg_valid_reg) begin
                    m_valid_reg <= 1'b1;
                end
            end
            if (flush_fire) begin
                res_cnt_reg   <= '0;
                stg_valid_reg <= 1'b0;
                if (stg_valid_reg) begin
                    m_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire && res_cnt_reg < 6'(MAX_RES)) begin
            stg_kind_reg <= cmd.kind;
            stg_byte_reg <= (cmd.kind == K_BYTE) ? e_byte : 8'h00;
            stg_line_reg <= (cmd.kind == K_UNTERM) ? bl16 : 16'h0000;
            stg_col_reg  <= (cmd.kind == K_UNTERM) ? bc16 : 16'h0000;
        end
        if ((emit_fire && res_cnt_reg < 6'(MAX_RES) || flush_fire) && stg_valid_reg) begin
            m_kind_reg    <= stg_kind_reg;
            m_byte_reg    <= stg_byte_reg;
            m_line_reg    <= stg_line_reg;
            m_col_reg     <= stg_col_reg;
            m_run_end_reg <= flush_fire;
        end
    end

    assign st.plan     = plan;
    assign st.lit_open = lit_reg;
    assign st.emit_ok  = !stg_valid_reg || out_free;
    assign st.flush_ok = !stg_valid_reg || out_free;
    assign st.b_quote  = (b_reg == CH_QUOTE);
    assign st.q_quote  = (ram_q == CH_QUOTE);
    assign ws_count    = cnt_reg;

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_out_byte = m_byte_reg;
    assign m_err_line = m_line_reg;
    assign m_err_col  = m_col_reg;
    assign m_run_end  = m_run_end_reg;
endmodule

>>> hw/rtl/tte_checker.sv
// Port-level checks for the template tag expander, bound to the top level.
// Depends on tte_pkg.
module tte_checker
    import tte_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_out_byte,
    input logic [15:0] m_err_line,
    input logic [15:0] m_err_col,
    input logic        m_run_end
);
    // a stream end is always the last result of its item
    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == K_DONE || m_kind == K_UNTERM) |-> m_run_end)
        else $error("stream end result without run_end");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != K_UNTERM |-> m_err_line == 16'h0 && m_err_col == 16'h0)
        else $error("position set on a result that is not an unterminated block");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != K_BYTE |-> m_out_byte == 8'h00)
        else $error("byte set on a status result");

    // no new item while results of the current one are still in flight
    a_no_accept_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_end |-> !s_ready)
        else $error("input ready while an item is still producing results");
endmodule

bind template_tag_expander tte_checker u_tte_checker (.*);
